@@ rtl/hpr_pkg.sv @@
// Package for the hashed partition router: payload types, status and
// strategy codes, hash constants. No dependencies.
`timescale 1ns / 1ps

package hpr_pkg;

	localparam int unsigned MAX_PARTITIONS_DEF         = 1024;
	localparam int unsigned SUPPORTED_HASH_VERSION_DEF = 1;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [63:0] FNV_MULT  = 64'h00000100000001b3;
	localparam logic [63:0] MIX_MUL1  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL2  = 64'h94d049bb133111eb;

	localparam logic [1:0] STRAT_KEY    = 2'd0;
	localparam logic [1:0] STRAT_HASH   = 2'd1;
	localparam logic [1:0] STRAT_SOURCE = 2'd2;
	localparam logic [1:0] STRAT_MANUAL = 2'd3;

	localparam logic [1:0] PHASE_ACTIVE = 2'd1;

	localparam logic [2:0] REG_STRATEGY   = 3'd0;
	localparam logic [2:0] REG_PHASE      = 3'd1;
	localparam logic [2:0] REG_TOTAL      = 3'd2;
	localparam logic [2:0] REG_SEED       = 3'd3;
	localparam logic [2:0] REG_REVISION   = 3'd4;
	localparam logic [2:0] REG_GENERATION = 3'd5;
	localparam logic [2:0] REG_HASH_VER   = 3'd6;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_MAP_INVALID = 3'd1,
		ST_UNSUPPORTED = 3'd2,
		ST_NOT_ACTIVE  = 3'd3,
		ST_REQ_INVALID = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0]  key_byte;
		logic        key_final;
		logic        key_absent;
		logic [63:0] given_hash;
		logic        given_hash_present;
		logic [63:0] node_ident;
		logic [63:0] publisher_ident;
		logic [63:0] publisher_era;
		logic [15:0] manual_target;
		logic        manual_present;
	} hpr_req_t;

	typedef struct packed {
		logic [2:0] route_status;
		logic [9:0] chosen_partition;
	} hpr_rsp_t;

endpackage

@@ rtl/hashed_partition_router.sv @@
// Top level of the hashed partition router: sequencer, shared multiplier
// and bit-serial modulo unit. Depends on hpr_pkg.
`timescale 1ns / 1ps

// The router takes one request word at a time and answers each message with
// one response word (status and partition). Requests that fail the map checks
// (key words that carry a byte apart), manual requests and key words that carry
// no byte skip the byte hashing. Hashed requests run every byte through FNV-1a
// on one shared 32x32 multiplier: an xor, then a 64-bit multiply built from
// partial products taken in turn. A key byte that opens a message absorbs 9
// bytes (seed and key byte), a later key byte one, a hash request 16 bytes and
// a source request 32 bytes. The final word of a message then adds the
// splitmix64 finalizer (two multiplies) and a restoring modulo that retires
// one dividend bit per cycle. A final key word with no byte that closes an open
// key goes straight to the finalizer. The request side is ready only while the
// sequencer is idle; a finished response sits in its own output register, so
// the next request is taken while it waits.
// Configuration must be written only while no request is in flight.
module hashed_partition_router #(
	parameter int unsigned MAX_PARTITIONS         = hpr_pkg::MAX_PARTITIONS_DEF,
	parameter int unsigned SUPPORTED_HASH_VERSION = hpr_pkg::SUPPORTED_HASH_VERSION_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              req_valid,
	output logic              req_ready,
	input  hpr_pkg::hpr_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output hpr_pkg::hpr_rsp_t rsp
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_ABSORB = 8'b0000_0010,
		S_MUL    = 8'b0000_0100,
		S_MIX_A  = 8'b0000_1000,
		S_MIX_B  = 8'b0001_0000,
		S_MIX_C  = 8'b0010_0000,
		S_DIV    = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	// Configuration registers.
	logic [1:0]  strategy_q;
	logic [1:0]  phase_q;
	logic [10:0] total_q;
	logic [63:0] seed_q;
	logic [63:0] revision_q;
	logic [63:0] generation_q;
	logic [7:0]  hash_ver_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q   <= hpr_pkg::STRAT_KEY;
			phase_q      <= '0;
			total_q      <= '0;
			seed_q       <= '0;
			revision_q   <= '0;
			generation_q <= '0;
			hash_ver_q   <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				hpr_pkg::REG_STRATEGY:   strategy_q   <= cfg_data[1:0];
				hpr_pkg::REG_PHASE:      phase_q      <= cfg_data[1:0];
				hpr_pkg::REG_TOTAL:      total_q      <= cfg_data[10:0];
				hpr_pkg::REG_SEED:       seed_q       <= cfg_data;
				hpr_pkg::REG_REVISION:   revision_q   <= cfg_data;
				hpr_pkg::REG_GENERATION: generation_q <= cfg_data;
				hpr_pkg::REG_HASH_VER:   hash_ver_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Map checks, evaluated against the registers seen when a word arrives.
	hpr_pkg::status_t map_st;
	always_comb begin
		if (revision_q == '0 || generation_q == '0 || total_q == '0 ||
				{6'd0, total_q} > 17'(MAX_PARTITIONS)) begin
			map_st = hpr_pkg::ST_MAP_INVALID;
		end else if (hash_ver_q != 8'(SUPPORTED_HASH_VERSION)) begin
			map_st = hpr_pkg::ST_UNSUPPORTED;
		end else if (phase_q != hpr_pkg::PHASE_ACTIVE) begin
			map_st = hpr_pkg::ST_NOT_ACTIVE;
		end else begin
			map_st = hpr_pkg::ST_OK;
		end
	end

	state_t           state_q;
	logic [63:0]      h_q;        // running hash, later the dividend
	logic [255:0]     buf_q;      // bytes still to absorb, lowest first
	logic [5:0]       cnt_q;      // bytes left in buf_q
	logic [1:0]       mstep_q;    // 0 absorbing, 1 after first mix, 2 after second
	logic [1:0]       mph_q;      // multiply phase
	logic [63:0]      mult_q;     // constant operand of the multiply
	logic [63:0]      acc_q;
	logic [10:0]      rem_q;
	logic [5:0]       dcnt_q;
	logic             key_open_q;
	logic             need_q;     // message ends with this word
	hpr_pkg::status_t res_st_q;
	logic [9:0]       res_part_q;
	logic             out_valid_q;
	hpr_pkg::hpr_rsp_t out_q;

	// Shared 32x32 multiplier: the low 64 bits of a 64x64 product are built
	// from lo*lo, lo*hi and hi*lo in turn.
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;
	always_comb begin
		case (mph_q)
			2'd0: begin
				op_a = h_q[31:0];
				op_b = mult_q[31:0];
			end
			2'd1: begin
				op_a = h_q[31:0];
				op_b = mult_q[63:32];
			end
			default: begin
				op_a = h_q[63:32];
				op_b = mult_q[31:0];
			end
		endcase
		prod = {32'd0, op_a} * {32'd0, op_b};
	end

	// One restoring division step.
	logic [11:0] rem_sh;
	logic [11:0] rem_sub;
	logic [10:0] rem_next;
	always_comb begin
		rem_sh   = {rem_q, h_q[63]};
		rem_sub  = rem_sh - {1'b0, total_q};
		rem_next = (rem_sh >= {1'b0, total_q}) ? rem_sub[10:0] : rem_sh[10:0];
	end

	assign req_ready = (state_q == S_IDLE);
	logic accept;
	assign accept = req_valid && req_ready;

	// A finished result moves to the output register once that register is free
	// or is being emptied in the same cycle.
	logic load_out;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_open_q  <= 1'b0;
			mph_q       <= '0;
			mstep_q     <= '0;
			cnt_q       <= '0;
			dcnt_q      <= '0;
			need_q      <= 1'b0;
			out_valid_q <= 1'b0;
			h_q         <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mstep_q <= '0;
						case (strategy_q)
							hpr_pkg::STRAT_KEY: begin
								need_q     <= req.key_final;
								res_part_q <= '0;
								if (!req.key_absent) begin
									res_st_q   <= map_st;
									key_open_q <= !req.key_final;
									if (!key_open_q) begin
										buf_q <= {184'd0, req.key_byte, seed_q};
										cnt_q <= 6'd9;
										h_q   <= hpr_pkg::FNV_BASIS;
									end else begin
										buf_q <= {248'd0, req.key_byte};
										cnt_q <= 6'd1;
									end
									state_q <= S_ABSORB;
								end else if (req.key_final) begin
									key_open_q <= 1'b0;
									if (map_st != hpr_pkg::ST_OK) begin
										res_st_q <= map_st;
										state_q  <= S_DONE;
									end else if (!key_open_q) begin
										res_st_q <= hpr_pkg::ST_REQ_INVALID;
										state_q  <= S_DONE;
									end else begin
										// The open key is closed with no new byte; the
										// running hash is already complete.
										res_st_q <= hpr_pkg::ST_OK;
										state_q  <= S_MIX_A;
									end
								end
							end
							hpr_pkg::STRAT_HASH: begin
								key_open_q <= 1'b0;
								need_q     <= 1'b1;
								res_part_q <= '0;
								if (map_st != hpr_pkg::ST_OK) begin
									res_st_q <= map_st;
									state_q  <= S_DONE;
								end else if (!req.given_hash_present) begin
									res_st_q <= hpr_pkg::ST_REQ_INVALID;
									state_q  <= S_DONE;
								end else begin
									res_st_q <= hpr_pkg::ST_OK;
									buf_q    <= {128'd0, req.given_hash, seed_q};
									cnt_q    <= 6'd16;
									h_q      <= hpr_pkg::FNV_BASIS;
									state_q  <= S_ABSORB;
								end
							end
							hpr_pkg::STRAT_SOURCE: begin
								key_open_q <= 1'b0;
								need_q     <= 1'b1;
								res_part_q <= '0;
								if (map_st != hpr_pkg::ST_OK) begin
									res_st_q <= map_st;
									state_q  <= S_DONE;
								end else if (req.node_ident == '0 ||
										req.publisher_ident == '0 ||
										req.publisher_era == '0) begin
									res_st_q <= hpr_pkg::ST_REQ_INVALID;
									state_q  <= S_DONE;
								end else begin
									res_st_q <= hpr_pkg::ST_OK;
									buf_q <= {req.publisher_era, req.publisher_ident,
										req.node_ident, seed_q};
									cnt_q   <= 6'd32;
									h_q     <= hpr_pkg::FNV_BASIS;
									state_q <= S_ABSORB;
								end
							end
							default: begin
								key_open_q <= 1'b0;
								state_q    <= S_DONE;
								if (map_st != hpr_pkg::ST_OK) begin
									res_st_q   <= map_st;
									res_part_q <= '0;
								end else if (!req.manual_present ||
										req.manual_target >= {5'd0, total_q}) begin
									res_st_q   <= hpr_pkg::ST_REQ_INVALID;
									res_part_q <= '0;
								end else begin
									res_st_q   <= hpr_pkg::ST_OK;
									res_part_q <= req.manual_target[9:0];
								end
							end
						endcase
					end
				end
				S_ABSORB: begin
					h_q     <= h_q ^ {56'd0, buf_q[7:0]};
					buf_q   <= {8'd0, buf_q[255:8]};
					cnt_q   <= cnt_q - 6'd1;
					mult_q  <= hpr_pkg::FNV_MULT;
					mph_q   <= 2'd0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					mph_q <= mph_q + 2'd1;
					case (mph_q)
						2'd0: acc_q <= prod;
						2'd1: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
						default: begin
							h_q <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
							case (mstep_q)
								2'd1: state_q <= S_MIX_B;
								2'd2: state_q <= S_MIX_C;
								default: begin
									if (cnt_q != '0) begin
										state_q <= S_ABSORB;
									end else if (!need_q) begin
										state_q <= S_IDLE;
									end else if (res_st_q != hpr_pkg::ST_OK) begin
										state_q <= S_DONE;
									end else begin
										state_q <= S_MIX_A;
									end
								end
							endcase
						end
					endcase
				end
				S_MIX_A: begin
					h_q     <= h_q ^ (h_q >> 30);
					mult_q  <= hpr_pkg::MIX_MUL1;
					mstep_q <= 2'd1;
					mph_q   <= 2'd0;
					state_q <= S_MUL;
				end
				S_MIX_B: begin
					h_q     <= h_q ^ (h_q >> 27);
					mult_q  <= hpr_pkg::MIX_MUL2;
					mstep_q <= 2'd2;
					mph_q   <= 2'd0;
					state_q <= S_MUL;
				end
				S_MIX_C: begin
					h_q     <= h_q ^ (h_q >> 31);
					rem_q   <= '0;
					dcnt_q  <= 6'd63;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= rem_next;
					h_q    <= {h_q[62:0], 1'b0};
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == '0) begin
						res_part_q <= rem_next[9:0];
						state_q    <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Response register; error statuses always carry partition zero.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.route_status     <= res_st_q;
			out_q.chosen_partition <= (res_st_q == hpr_pkg::ST_OK) ? res_part_q : 10'd0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.route_status != hpr_pkg::ST_OK |-> rsp.chosen_partition == '0)
		else $error("error response with nonzero partition");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < total_q)
		else $error("modulo remainder out of range");
	a_mul_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL && mph_q == 2'd2 |=> state_q != S_MUL || mph_q == 2'd0)
		else $error("multiply ran past three phases");
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.route_status == hpr_pkg::ST_OK |->
			{1'b0, rsp.chosen_partition} < total_q)
		else $error("partition not below partition count");

endmodule
